>>> hdl/dgf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dgf_pkg
// Shared types, widths and scaling constants of the diagonal glow filter.
// ----------------------------------------------------------------------------
package dgf_pkg;

    localparam int PIX_W           = 16;
    localparam int NUM_CHAN        = 3;
    localparam int NUM_NB          = 4;
    localparam int COORD_W         = 9;
    localparam int CFG_W           = 10;
    localparam int MAX_DIM_DEFAULT = 512;
    localparam int DIM_RESET       = 512;
    localparam int S_DATA_W        = 48;
    localparam int M_DATA_W        = 72;

    // channel index inside pixel_t
    localparam int CH_RED   = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 0;

    // three rows live in the row memory, row r in slot r mod 3
    localparam int NUM_SLOTS = 3;
    localparam int SLOT_W    = 2;

    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // floor(x*3/10) and floor(x*4/25) as multiply by rounded-up reciprocal,
    // exact for all 16-bit x
    localparam int SCALE_SHIFT = 24;
    localparam int CTR_K_W     = 23;
    localparam int NB_K_W      = 22;
    localparam logic [CTR_K_W-1:0] CTR_K = 23'd5033165;
    localparam logic [NB_K_W-1:0]  NB_K  = 22'd2684355;

    typedef logic [NUM_CHAN-1:0][PIX_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t                   ctr;
        pixel_t [NUM_NB-1:0]      nb;
        logic [COORD_W-1:0]       row;
        logic [COORD_W-1:0]       col;
        logic                     run_last;
        logic                     frame_end;
    } emit_req_t;

    typedef struct packed {
        pixel_t                   pix;
        logic [COORD_W-1:0]       row;
        logic [COORD_W-1:0]       col;
        logic                     run_last;
        logic                     frame_end;
    } result_t;

    function automatic logic [SLOT_W-1:0] slot_step(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(NUM_SLOTS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    function automatic logic [PIX_W-1:0] scale_ctr(input logic [PIX_W-1:0] x);
        logic [PIX_W+CTR_K_W-1:0] p;
        p = (PIX_W + CTR_K_W)'(x) * (PIX_W + CTR_K_W)'(CTR_K);
        return PIX_W'(p >> SCALE_SHIFT);
    endfunction

    function automatic logic [PIX_W-1:0] scale_nb(input logic [PIX_W-1:0] x);
        logic [PIX_W+NB_K_W-1:0] p;
        p = (PIX_W + NB_K_W)'(x) * (PIX_W + NB_K_W)'(NB_K);
        return PIX_W'(p >> SCALE_SHIFT);
    endfunction

endpackage
`default_nettype wire

>>> hdl/dgf_line_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dgf_line_store
// Three-row pixel memory plus fetch stage: writes the incoming pixel and
// reads the two rows above it at the same column.
// ----------------------------------------------------------------------------
module dgf_line_store
    import dgf_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       wr_en,
    input  wire logic [SLOT_W-1:0]          slot,
    input  wire logic [$clog2(MAX_DIM)-1:0] row,
    input  wire logic [$clog2(MAX_DIM)-1:0] col,
    input  wire pixel_t                     pix,
    input  wire logic                       take,
    output logic                            f_valid,
    output pixel_t                          f_top,
    output pixel_t                          f_mid,
    output pixel_t                          f_bot,
    output logic [$clog2(MAX_DIM)-1:0]      f_row,
    output logic [$clog2(MAX_DIM)-1:0]      f_col
);

    localparam int CW    = $clog2(MAX_DIM);
    localparam int DEPTH = NUM_SLOTS * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    pixel_t            row_mem [DEPTH];
    pixel_t            top_reg, mid_reg, bot_reg;
    logic [CW-1:0]     row_reg, col_reg;
    logic              valid_reg;
    logic [AW-1:0]     wr_addr, top_addr, mid_addr;
    logic [SLOT_W-1:0] top_slot, mid_slot;

    function automatic logic [AW-1:0] slot_base(input logic [SLOT_W-1:0] s);
        case (s)
            2'd0:    return '0;
            2'd1:    return AW'(MAX_DIM);
            2'd2:    return AW'(2 * MAX_DIM);
            default: return '0;
        endcase
    endfunction

    // row r-2 sits one slot ahead, row r-1 two slots ahead
    assign top_slot = slot_step(slot);
    assign mid_slot = slot_step(top_slot);
    assign wr_addr  = slot_base(slot) + AW'(col);
    assign top_addr = slot_base(top_slot) + AW'(col);
    assign mid_addr = slot_base(mid_slot) + AW'(col);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_mem[wr_addr] <= pix;
            top_reg          <= row_mem[top_addr];
            mid_reg          <= row_mem[mid_addr];
            bot_reg          <= pix;
            row_reg          <= row;
            col_reg          <= col;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (wr_en) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    assign f_valid = valid_reg;
    assign f_top   = top_reg;
    assign f_mid   = mid_reg;
    assign f_bot   = bot_reg;
    assign f_row   = row_reg;
    assign f_col   = col_reg;

endmodule
`default_nettype wire

>>> hdl/dgf_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dgf_window
// 3x3 pixel window and emit sequencer: one request per cycle, while the output
// queue has room, for each output pixel that the newest column completes.
// ----------------------------------------------------------------------------
module dgf_window
    import dgf_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       f_valid,
    input  wire pixel_t                     f_top,
    input  wire pixel_t                     f_mid,
    input  wire pixel_t                     f_bot,
    input  wire logic [$clog2(MAX_DIM)-1:0] f_row,
    input  wire logic [$clog2(MAX_DIM)-1:0] f_col,
    input  wire logic [$clog2(MAX_DIM)-1:0] dim_last,
    input  wire logic                       room,
    output logic                            take,
    output logic                            reserve,
    output logic                            req_valid,
    output emit_req_t                       req
);

    localparam int CW        = $clog2(MAX_DIM);
    localparam int NUM_EM    = 4;
    localparam int EM_INNER  = 0;   // (r-1, c-1)
    localparam int EM_RIGHT  = 1;   // (r-1, last col)
    localparam int EM_BOTTOM = 2;   // (last row, c-1)
    localparam int EM_CORNER = 3;   // (last row, last col)

    // index 0 holds column c-2, index 2 column c
    pixel_t            top_reg [3];
    pixel_t            mid_reg [3];
    pixel_t            bot_reg [3];
    logic [CW-1:0]     row_reg, col_reg;
    logic [NUM_EM-1:0] pend_reg, pend_next, new_pend, sel, pend_left;
    emit_req_t         req_reg, req_next;
    logic              req_valid_reg;
    logic              issue;
    logic              row_ge2, col_ge2;
    logic [CW-1:0]     em_row, em_col;

    assign new_pend[EM_INNER]  = (f_row != '0) && (f_col != '0);
    assign new_pend[EM_RIGHT]  = (f_row != '0) && (f_col == dim_last);
    assign new_pend[EM_BOTTOM] = (f_row == dim_last) && (f_col != '0);
    assign new_pend[EM_CORNER] = (f_row == dim_last) && (f_col == dim_last);

    assign sel       = pend_reg & (~pend_reg + NUM_EM'(1));
    assign pend_left = pend_reg & ~sel;
    assign issue     = (pend_reg != '0) && room;
    assign take      = f_valid && ((pend_reg == '0) || (issue && (pend_left == '0)));

    always_comb begin
        if (take) begin
            pend_next = new_pend;
        end else if (issue) begin
            pend_next = pend_left;
        end else begin
            pend_next = pend_reg;
        end
    end

    assign row_ge2 = row_reg > CW'(1);
    assign col_ge2 = col_reg > CW'(1);

    // neighbors outside the image are forced to zero
    always_comb begin
        req_next = '0;
        if (sel[EM_INNER]) begin
            em_row         = row_reg - CW'(1);
            em_col         = col_reg - CW'(1);
            req_next.ctr   = mid_reg[1];
            req_next.nb[0] = (row_ge2 && col_ge2) ? top_reg[0] : '0;
            req_next.nb[1] = row_ge2 ? top_reg[2] : '0;
            req_next.nb[2] = col_ge2 ? bot_reg[0] : '0;
            req_next.nb[3] = bot_reg[2];
        end else if (sel[EM_RIGHT]) begin
            em_row         = row_reg - CW'(1);
            em_col         = col_reg;
            req_next.ctr   = mid_reg[2];
            req_next.nb[0] = row_ge2 ? top_reg[1] : '0;
            req_next.nb[1] = bot_reg[1];
        end else if (sel[EM_BOTTOM]) begin
            em_row         = row_reg;
            em_col         = col_reg - CW'(1);
            req_next.ctr   = bot_reg[1];
            req_next.nb[0] = col_ge2 ? mid_reg[0] : '0;
            req_next.nb[1] = mid_reg[2];
        end else begin
            em_row         = row_reg;
            em_col         = col_reg;
            req_next.ctr   = bot_reg[2];
            req_next.nb[0] = mid_reg[1];
        end
        req_next.row       = COORD_W'(em_row);
        req_next.col       = COORD_W'(em_col);
        req_next.run_last  = (pend_left == '0);
        req_next.frame_end = (em_row == dim_last) && (em_col == dim_last);
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            top_reg[0] <= top_reg[1];
            top_reg[1] <= top_reg[2];
            top_reg[2] <= f_top;
            mid_reg[0] <= mid_reg[1];
            mid_reg[1] <= mid_reg[2];
            mid_reg[2] <= f_mid;
            bot_reg[0] <= bot_reg[1];
            bot_reg[1] <= bot_reg[2];
            bot_reg[2] <= f_bot;
            row_reg    <= f_row;
            col_reg    <= f_col;
        end
        if (issue) begin
            req_reg <= req_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= '0;
            req_valid_reg <= 1'b0;
        end else begin
            pend_reg      <= pend_next;
            req_valid_reg <= issue;
        end
    end

    assign reserve   = issue;
    assign req_valid = req_valid_reg;
    assign req       = req_reg;

endmodule
`default_nettype wire

>>> hdl/dgf_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dgf_scale
// Constant scaling of center and neighbor channels, registered, then the
// five-term sum per channel.
// ----------------------------------------------------------------------------
module dgf_scale
    import dgf_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      req_valid,
    input  wire emit_req_t req,
    output logic           res_valid,
    output result_t        res
);

    logic [PIX_W-1:0]   ctr_term_reg [NUM_CHAN];
    logic [PIX_W-1:0]   nb_term_reg  [NUM_NB][NUM_CHAN];
    logic [COORD_W-1:0] row_reg, col_reg;
    logic               last_reg, fend_reg, valid_reg;
    logic [PIX_W+2:0]   acc;

    always_ff @(posedge aclk) begin
        if (req_valid) begin
            for (int ch = 0; ch < NUM_CHAN; ch++) begin
                ctr_term_reg[ch] <= scale_ctr(req.ctr[ch]);
                for (int n = 0; n < NUM_NB; n++) begin
                    nb_term_reg[n][ch] <= scale_nb(req.nb[n][ch]);
                end
            end
            row_reg  <= req.row;
            col_reg  <= req.col;
            last_reg <= req.run_last;
            fend_reg <= req.frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= req_valid;
        end
    end

    // peak sum is 61600, never wraps 16 bits
    always_comb begin
        res = '0;
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            acc = (PIX_W + 3)'(ctr_term_reg[ch]);
            for (int n = 0; n < NUM_NB; n++) begin
                acc = acc + (PIX_W + 3)'(nb_term_reg[n][ch]);
            end
            res.pix[ch] = PIX_W'(acc);
        end
        res.row       = row_reg;
        res.col       = col_reg;
        res.run_last  = last_reg;
        res.frame_end = fend_reg;
    end

    assign res_valid = valid_reg;

endmodule
`default_nettype wire

>>> hdl/dgf_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dgf_out_fifo
// Output word queue with a credit count that covers words still in the
// scaling pipeline, so upstream never sees m_tready directly.
// ----------------------------------------------------------------------------
module dgf_out_fifo
    import dgf_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    reserve,
    input  wire logic    push,
    input  wire result_t push_data,
    input  wire logic    pop_ready,
    output logic         room,
    output logic         out_valid,
    output result_t      out_data
);

    result_t               entry_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0]  fill_reg, fill_next, credit_reg, credit_next;
    logic                  pop;

    assign out_valid = (fill_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && pop_ready;
    assign room      = (credit_reg != OUT_CNT_W'(OUT_DEPTH));

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                        : wr_ptr_reg + OUT_PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                        : rd_ptr_reg + OUT_PTR_W'(1);
        end
        fill_next   = fill_reg + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
        credit_next = credit_reg + OUT_CNT_W'(reserve) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            credit_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            credit_reg <= credit_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/diagonal_glow_filter.sv
// The first result word of an input passes the fetch, request and scaling registers
// and the output queue; its further words follow one per cycle while the queue has
// room. Throughput: one pixel per cycle with room; an input that completes several
// pixels (up to 4, in the last column or last row) holds s_tready low until issued.
// Output queue holds 8 words; once it is committed, s_tready waits on m_tready.
// Reset (aresetn low, synchronous): clears position, pipeline, queue; dimension 512.
`default_nettype none
// ----------------------------------------------------------------------------
// diagonal_glow_filter
// Diagonal 3x3 glow filter over a square RGB image streamed in raster order.
// ----------------------------------------------------------------------------
module diagonal_glow_filter
    import dgf_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [CFG_W-1:0]    cfg_wdata,     // side length in pixels
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,       // in_red, in_green, in_blue
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,       // out_red, out_green, out_blue,
                                                    // out_row, out_col, zero pad
    output logic                     m_tlast,       // run_last
    output logic                     m_tuser        // frame_end
);

    localparam int CW        = $clog2(MAX_DIM);
    localparam int RESET_DIM = (DIM_RESET > MAX_DIM) ? MAX_DIM : DIM_RESET;
    localparam int PAD_W     = M_DATA_W - NUM_CHAN * PIX_W - 2 * COORD_W;

    logic [CW-1:0]     row_reg, row_next, col_reg, col_next;
    logic [CW-1:0]     dim_last_reg, dim_last_next, cfg_last;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [31:0]       cfg_dim;
    logic              accept;
    pixel_t            pix_in;

    logic              f_valid, f_take;
    pixel_t            f_top, f_mid, f_bot;
    logic [CW-1:0]     f_row, f_col;
    logic              room, reserve, req_valid, res_valid;
    emit_req_t         req;
    result_t           res, head;

    assign accept = s_tvalid && s_tready;
    assign s_tready = !f_valid || f_take;

    assign pix_in[CH_RED]   = s_tdata[PIX_W-1:0];
    assign pix_in[CH_GREEN] = s_tdata[2*PIX_W-1:PIX_W];
    assign pix_in[CH_BLUE]  = s_tdata[3*PIX_W-1:2*PIX_W];

    // dimension clamped to [2, MAX_DIM], held as last index
    assign cfg_dim  = 32'(cfg_wdata);
    assign cfg_last = (cfg_dim < 32'd2) ? CW'(1)
                    : (cfg_dim > 32'(MAX_DIM)) ? CW'(MAX_DIM - 1)
                    : CW'(cfg_dim - 32'd1);

    always_comb begin
        row_next      = row_reg;
        col_next      = col_reg;
        slot_next     = slot_reg;
        dim_last_next = dim_last_reg;
        if (cfg_we) begin
            dim_last_next = cfg_last;
            row_next      = '0;
            col_next      = '0;
            slot_next     = '0;
        end else if (accept) begin
            if (col_reg == dim_last_reg) begin
                col_next = '0;
                if (row_reg == dim_last_reg) begin
                    row_next  = '0;
                    slot_next = '0;
                end else begin
                    row_next  = row_reg + CW'(1);
                    slot_next = slot_step(slot_reg);
                end
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            slot_reg     <= '0;
            dim_last_reg <= CW'(RESET_DIM - 1);
        end else begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            slot_reg     <= slot_next;
            dim_last_reg <= dim_last_next;
        end
    end

    dgf_line_store #(
        .MAX_DIM (MAX_DIM)
    ) u_line_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (accept),
        .slot    (slot_reg),
        .row     (row_reg),
        .col     (col_reg),
        .pix     (pix_in),
        .take    (f_take),
        .f_valid (f_valid),
        .f_top   (f_top),
        .f_mid   (f_mid),
        .f_bot   (f_bot),
        .f_row   (f_row),
        .f_col   (f_col)
    );

    dgf_window #(
        .MAX_DIM (MAX_DIM)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .f_valid   (f_valid),
        .f_top     (f_top),
        .f_mid     (f_mid),
        .f_bot     (f_bot),
        .f_row     (f_row),
        .f_col     (f_col),
        .dim_last  (dim_last_reg),
        .room      (room),
        .take      (f_take),
        .reserve   (reserve),
        .req_valid (req_valid),
        .req       (req)
    );

    dgf_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (req_valid),
        .req       (req),
        .res_valid (res_valid),
        .res       (res)
    );

    dgf_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .reserve   (reserve),
        .push      (res_valid),
        .push_data (res),
        .pop_ready (m_tready),
        .room      (room),
        .out_valid (m_tvalid),
        .out_data  (head)
    );

    assign m_tdata = {{PAD_W{1'b0}}, head.col, head.row,
                      head.pix[CH_BLUE], head.pix[CH_GREEN], head.pix[CH_RED]};
    assign m_tlast = head.run_last;
    assign m_tuser = head.frame_end;

endmodule
`default_nettype wire

>>> hdl/dgf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dgf_checker
// Port-level checks on the result stream of the diagonal glow filter.
// ----------------------------------------------------------------------------
module dgf_checker
    import dgf_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic                m_tlast,
    input wire logic                m_tuser
);

    localparam int ROW_LSB = NUM_CHAN * PIX_W;
    localparam int COL_LSB = ROW_LSB + COORD_W;
    localparam int PAD_LSB = COL_LSB + COORD_W;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result word changed");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_DATA_W-1:PAD_LSB] == '0)
        else $error("tdata pad bits not zero");

    a_frame_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end word is not the last of its run");

    a_frame_end_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            m_tdata[ROW_LSB +: COORD_W] == m_tdata[COL_LSB +: COORD_W])
        else $error("frame end word off the bottom-right corner");

endmodule

bind diagonal_glow_filter dgf_checker u_dgf_checker (.*);
`default_nettype wire
